// ===== design/rpm_pkg.sv =====
package rpm_pkg;

  localparam int BOX_W_CFG_W = 13;
  localparam int BOX_H_CFG_W = 11;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int PIX_W       = 8;
  localparam int RGB_W       = 3 * PIX_W;
  localparam int POS_X_W     = 12;
  localparam int POS_Y_W     = 10;
  localparam int ENTRY_W     = RGB_W + 2;

  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_WIDTH  = 4096;

  localparam int OFIFO_DEPTH = 8;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONNECTIVITY = 2'd2;

  typedef struct packed {
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
    logic [PIX_W-1:0]   blue;
    logic [PIX_W-1:0]   green;
    logic [PIX_W-1:0]   red;
    logic               last;
  } result_t;

  // up to two words per cell; push_b only ever comes with push_a
  typedef struct packed {
    logic    push_a;
    logic    push_b;
    result_t a;
    result_t b;
  } push_t;

endpackage

// ===== design/rpm_if.sv =====
interface rpm_in_if;
  logic                    valid;
  logic                    ready;
  logic                    in_region;
  logic [rpm_pkg::PIX_W-1:0] blue_in;
  logic [rpm_pkg::PIX_W-1:0] green_in;
  logic [rpm_pkg::PIX_W-1:0] red_in;

  modport source (output valid, in_region, blue_in, green_in, red_in, input ready);
  modport sink   (input valid, in_region, blue_in, green_in, red_in, output ready);
endinterface

interface rpm_out_if;
  logic                        valid;
  logic                        ready;
  logic [rpm_pkg::POS_X_W-1:0] pos_x;
  logic [rpm_pkg::POS_Y_W-1:0] pos_y;
  logic [rpm_pkg::PIX_W-1:0]   blue_out;
  logic [rpm_pkg::PIX_W-1:0]   green_out;
  logic [rpm_pkg::PIX_W-1:0]   red_out;
  logic                        last_of_item;

  modport source (output valid, pos_x, pos_y, blue_out, green_out, red_out, last_of_item,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, blue_out, green_out, red_out, last_of_item,
                  output ready);
endinterface

// ===== design/rpm_ram.sv =====
module rpm_ram #(
  parameter int WIDTH = rpm_pkg::ENTRY_W,
  parameter int DEPTH = rpm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word when the same entry is written in that cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== design/rpm_out_fifo.sv =====
module rpm_out_fifo #(
  parameter int DEPTH = rpm_pkg::OFIFO_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rpm_pkg::push_t           push_i,
  input  logic                     pop_i,
  output logic                     valid_o,
  output rpm_pkg::result_t         data_o,
  output logic [$clog2(DEPTH):0]   count_o
);

  localparam int AW = $clog2(DEPTH);

  rpm_pkg::result_t mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]   count_q, count_d;
  logic [AW-1:0] wr_next;
  logic          pop;

  assign pop     = pop_i & valid_o;
  assign wr_next = wr_q + AW'(1);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_q];
  assign count_o = count_q;

  always_comb begin
    wr_d    = wr_q + AW'(push_i.push_a) + AW'(push_i.push_b);
    rd_d    = rd_q + AW'(pop);
    count_d = count_q + (AW+1)'(push_i.push_a) + (AW+1)'(push_i.push_b) - (AW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push_a) begin
      mem_q[wr_q] <= push_i.a;
    end
    if (push_i.push_b) begin
      mem_q[wr_next] <= push_i.b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH)
    else $error("output queue overflow");

  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push_b |-> push_i.push_a)
    else $error("second word pushed without first");
`endif

endmodule

// ===== design/region_perimeter_marker_core.sv =====
// Region perimeter marker.
// Cells of a bounding box come in on in_i column by column (x outer, y inner),
// one word per cycle: membership bit plus blue/green/red. Each perimeter
// member cell leaves on out_o with its box position and colour; last_of_item
// marks the final word caused by one input cell (zero, one or two words).
// Edge cells are reported as they arrive; an interior cell is reported when
// its lower-right neighbour arrives, ahead of that neighbour's own word.
// Throughput: one cell per cycle, set by the single read-modify-write of the
// column store (one read port, one write port) per cell.
// A cell is accepted into the update stage; its words go into the output FIFO.
// Stalls: results queue in an 8-word output FIFO; in_i.ready drops while the
// FIFO could not take the words of one more cell, and recovers as out_o drains.
// Configuration: cfg_we_i writes box_width (0), box_height (1) or connectivity
// (2); the user must write only while idle, which the block does not enforce;
// any such write restarts the box at (0,0). Reset: box 1x1, four-neighbour
// mode, position (0,0), queue empty. The column store is not cleared; every
// stored value that a box uses it wrote itself.
module region_perimeter_marker_core #(
  parameter int MAX_HEIGHT = rpm_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH  = rpm_pkg::DEF_MAX_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rpm_in_if.sink                          in_i,
  rpm_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [rpm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rpm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int EW  = rpm_pkg::ENTRY_W;
  localparam int RW  = rpm_pkg::RGB_W;
  localparam int FD  = rpm_pkg::OFIFO_DEPTH;
  localparam int FCW = $clog2(FD) + 1;

  // configuration
  logic [rpm_pkg::BOX_W_CFG_W-1:0] box_width_q, box_width_d;
  logic [rpm_pkg::BOX_H_CFG_W-1:0] box_height_q, box_height_d;
  logic                            conn_q, conn_d;
  logic                            cfg_hit;
  logic [31:0]                     w_eff, h_eff;

  // position of the next cell
  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic          accept, x_last, y_last, on_edge;

  // cell in the update stage
  logic          s1_valid_q;
  logic [XW-1:0] s1_x_q;
  logic [YW-1:0] s1_y_q;
  logic          s1_m_q, s1_edge_q, s1_int_q;
  logic [RW-1:0] s1_rgb_q;
  logic          fwd_q;
  logic [EW-1:0] fwd_data_q;

  logic [5:0]    window_q, window_d;
  logic [RW-1:0] centre_q, centre_d;

  logic [EW-1:0] rdata, entry, wdata;
  logic [2:0]    cur, up, mid;
  logic          bnd4, bnd8, int_hit, edge_hit;
  logic [31:0]   xm1_ext, ym1_ext, x_ext, y_ext;

  rpm_pkg::push_t   push;
  rpm_pkg::result_t res_int, res_edge, fifo_data;
  logic             fifo_valid;
  logic [FCW-1:0]   fifo_count;

  // ---------------- configuration
  always_comb begin
    box_width_d  = box_width_q;
    box_height_d = box_height_q;
    conn_d       = conn_q;
    cfg_hit      = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rpm_pkg::REG_BOX_WIDTH: begin
          box_width_d = cfg_data_i[rpm_pkg::BOX_W_CFG_W-1:0];
          cfg_hit     = 1'b1;
        end
        rpm_pkg::REG_BOX_HEIGHT: begin
          box_height_d = cfg_data_i[rpm_pkg::BOX_H_CFG_W-1:0];
          cfg_hit      = 1'b1;
        end
        rpm_pkg::REG_CONNECTIVITY: begin
          conn_d  = cfg_data_i[0];
          cfg_hit = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (box_width_q == '0) begin
      w_eff = 32'd1;
    end else if (32'(box_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = 32'(MAX_WIDTH);
    end else begin
      w_eff = 32'(box_width_q);
    end
    if (box_height_q == '0) begin
      h_eff = 32'd1;
    end else if (32'(box_height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = 32'(MAX_HEIGHT);
    end else begin
      h_eff = 32'(box_height_q);
    end
  end

  // ---------------- input stage: position and store read
  assign in_i.ready = (s1_valid_q) ? (32'(fifo_count) <= FD - 4)
                                   : (32'(fifo_count) <= FD - 2);
  assign accept  = in_i.valid & in_i.ready;
  assign x_last  = (32'(x_q) + 32'd1 >= w_eff);
  assign y_last  = (32'(y_q) + 32'd1 >= h_eff);
  assign on_edge = (x_q == '0) | (y_q == '0) | x_last | y_last;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (accept) begin
      if (y_last) begin
        y_d = '0;
        x_d = x_last ? '0 : x_q + XW'(1);
      end else begin
        y_d = y_q + YW'(1);
      end
    end
    if (cfg_hit) begin
      x_d = '0;
      y_d = '0;
    end
  end

  rpm_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_HEIGHT)
  ) u_column_store (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_y_q),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (y_q),
    .rdata_o (rdata)
  );

  // ---------------- update stage
  // same row written back in the cycle it is read again (one-row box)
  assign entry = fwd_q ? fwd_data_q : rdata;
  assign cur   = {entry[EW-1], entry[EW-2], s1_m_q};
  assign up    = window_q[5:3];
  assign mid   = window_q[2:0];
  assign wdata = {entry[EW-2], s1_m_q, s1_rgb_q};

  assign bnd4 = !up[1] | !cur[1] | !mid[2] | !mid[0];
  assign bnd8 = bnd4 | !up[2] | !up[0] | !cur[2] | !cur[0];

  assign int_hit  = s1_valid_q & s1_int_q & mid[1] & (conn_q ? bnd8 : bnd4);
  assign edge_hit = s1_valid_q & s1_edge_q;

  assign xm1_ext = 32'(s1_x_q - XW'(1));
  assign ym1_ext = 32'(s1_y_q - YW'(1));
  assign x_ext   = 32'(s1_x_q);
  assign y_ext   = 32'(s1_y_q);

  always_comb begin
    res_int.pos_x = xm1_ext[rpm_pkg::POS_X_W-1:0];
    res_int.pos_y = ym1_ext[rpm_pkg::POS_Y_W-1:0];
    res_int.blue  = centre_q[7:0];
    res_int.green = centre_q[15:8];
    res_int.red   = centre_q[23:16];
    res_int.last  = !edge_hit;

    res_edge.pos_x = x_ext[rpm_pkg::POS_X_W-1:0];
    res_edge.pos_y = y_ext[rpm_pkg::POS_Y_W-1:0];
    res_edge.blue  = s1_rgb_q[7:0];
    res_edge.green = s1_rgb_q[15:8];
    res_edge.red   = s1_rgb_q[23:16];
    res_edge.last  = 1'b1;

    push.push_a = int_hit | edge_hit;
    push.push_b = int_hit & edge_hit;
    push.a      = int_hit ? res_int : res_edge;
    push.b      = res_edge;
  end

  always_comb begin
    window_d = window_q;
    centre_d = centre_q;
    if (s1_valid_q) begin
      window_d = {mid, cur};
      centre_d = entry[RW-1:0];
    end
  end

  // ---------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_width_q  <= rpm_pkg::BOX_W_CFG_W'(1);
      box_height_q <= rpm_pkg::BOX_H_CFG_W'(1);
      conn_q       <= 1'b0;
      x_q          <= '0;
      y_q          <= '0;
      s1_valid_q   <= 1'b0;
      fwd_q        <= 1'b0;
      window_q     <= '0;
      centre_q     <= '0;
    end else begin
      box_width_q  <= box_width_d;
      box_height_q <= box_height_d;
      conn_q       <= conn_d;
      x_q          <= x_d;
      y_q          <= y_d;
      s1_valid_q   <= accept;
      if (accept) begin
        fwd_q <= s1_valid_q & (s1_y_q == y_q);
      end
      window_q     <= window_d;
      centre_q     <= centre_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q     <= x_q;
      s1_y_q     <= y_q;
      s1_m_q     <= in_i.in_region;
      s1_rgb_q   <= {in_i.red_in, in_i.green_in, in_i.blue_in};
      s1_edge_q  <= in_i.in_region & on_edge;
      s1_int_q   <= (32'(x_q) >= 32'd2) & (32'(y_q) >= 32'd2);
      fwd_data_q <= wdata;
    end
  end

  // ---------------- output queue
  rpm_out_fifo #(
    .DEPTH (FD)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_o.ready),
    .valid_o (fifo_valid),
    .data_o  (fifo_data),
    .count_o (fifo_count)
  );

  assign out_o.valid        = fifo_valid;
  assign out_o.pos_x        = fifo_data.pos_x;
  assign out_o.pos_y        = fifo_data.pos_y;
  assign out_o.blue_out     = fifo_data.blue;
  assign out_o.green_out    = fifo_data.green;
  assign out_o.red_out      = fifo_data.red;
  assign out_o.last_of_item = fifo_data.last;

`ifndef SYNTH
  a_x_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(x_q) < w_eff)
    else $error("column position outside box");

  a_one_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !cfg_we_i && (h_eff == 32'd1) |=> (y_q == '0))
    else $error("row moved in a one-row box");
`endif

endmodule
